/* rtl/nca_pkg.sv */
// Shared types and constants for the nearest-centroid assignment block.
// Used by nca_cell, nca_seq and nearest_centroid_assign_top; depends on nothing.
package nca_pkg;

   // Default sizes, handed down through the top-level parameters.
   localparam int DEF_MAX_CLUSTERS = 16;
   localparam int DEF_MAX_DIMS     = 16;
   localparam int DEF_COORD_BITS   = 16;

   // Fixed field widths of the channels.
   localparam int OP_BITS            = 2;
   localparam int CLUSTER_INDEX_BITS = 4;
   localparam int DIM_INDEX_BITS     = 4;
   localparam int LABEL_BITS         = 5;
   localparam int CFG_BITS           = 5;
   localparam int CSR_INDEX_BITS     = 1;
   localparam int COUNT_BITS         = 20;

   // Distance arithmetic: a magnitude of 2^20 or more saturates the square.
   localparam int SQ_MAG_BITS = 20;
   localparam int ACC_BITS    = 40;
   localparam logic [ACC_BITS-1:0]   ACC_MAX   = {ACC_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Register reset values.
   localparam logic [CFG_BITS-1:0] CLUSTERS_RESET = CFG_BITS'(16);
   localparam logic [CFG_BITS-1:0] DIMS_RESET     = CFG_BITS'(16);

   // Item operation codes.
   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD  = 2'd0,
      OP_POINT = 2'd1,
      OP_START = 2'd2
   } nca_op_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CLUSTERS = 1'b0,
      CSR_DIMS     = 1'b1
   } nca_csr_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SQUARE,
      ST_ACCUM,
      ST_SEED,
      ST_SCAN,
      ST_EMIT
   } nca_state_type;

   // Strobes broadcast from the sequencer to every cell.
   typedef struct packed {
      logic rd_en;
      logic sq_en;
      logic acc_en;
      logic acc_clear;
   } nca_cell_ctrl_type;

endpackage

/* rtl/nca_cell.sv */
// One centroid cell: its column of coordinates, a squared-distance accumulator
// and one stage of the minimum-search chain. Depends on nca_pkg.
module nca_cell
   import nca_pkg::*;
#(
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
   parameter int MAX_DIMS     = DEF_MAX_DIMS,
   parameter int COORD_BITS   = DEF_COORD_BITS,
   parameter int CELL_INDEX   = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nca_cell_ctrl_type                     ctrl,
   input  logic                                  wr_en,
   input  logic                                  active,
   input  logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0] addr,
   input  logic signed [COORD_BITS-1:0]          coord,
   input  logic                                  scan_valid_in,
   input  logic [ACC_BITS-1:0]                   scan_dist_in,
   input  logic [$clog2(MAX_CLUSTERS)-1:0]       scan_idx_in,
   output logic                                  scan_valid_out,
   output logic [ACC_BITS-1:0]                   scan_dist_out,
   output logic [$clog2(MAX_CLUSTERS)-1:0]       scan_idx_out
);

   localparam int CLU_W  = $clog2(MAX_CLUSTERS);
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int WIDE_W = (DIFF_W > SQ_MAG_BITS + 1) ? DIFF_W : SQ_MAG_BITS + 1;

   logic signed [COORD_BITS-1:0] store_mem [MAX_DIMS];
   logic signed [COORD_BITS-1:0] cent_ff;
   logic [ACC_BITS-1:0]          sq_ff;
   logic [ACC_BITS-1:0]          acc_ff;
   logic                         scan_valid_ff;
   logic [ACC_BITS-1:0]          scan_dist_ff;
   logic [CLU_W-1:0]             scan_idx_ff;

   logic [DIFF_W-1:0]          diff;
   logic [DIFF_W-1:0]          mag;
   logic [WIDE_W-1:0]          mag_wide;
   logic                       mag_over;
   logic [SQ_MAG_BITS-1:0]     mag_low;
   logic [2*SQ_MAG_BITS-1:0]   product;
   logic [ACC_BITS-1:0]        acc_base;
   logic [ACC_BITS:0]          acc_sum;
   logic                       take_own;

   // Coordinate store for this centroid, with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[addr] <= coord;
      end
      if (ctrl.rd_en) begin
         cent_ff <= store_mem[addr];
      end
   end

   // Exact difference, its magnitude and the saturating square.
   always_comb begin
      diff     = DIFF_W'({coord[COORD_BITS-1], coord} - {cent_ff[COORD_BITS-1], cent_ff});
      mag      = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      mag_wide = WIDE_W'(mag);
      mag_over = |mag_wide[WIDE_W-1:SQ_MAG_BITS];
      mag_low  = mag_wide[SQ_MAG_BITS-1:0];
      product  = mag_low * mag_low;
   end

   always_ff @(posedge clock) begin
      if (ctrl.sq_en) begin
         sq_ff <= mag_over ? ACC_MAX : ACC_BITS'(product);
      end
   end

   // Saturating accumulation; the first dimension of a point restarts the sum.
   always_comb begin
      acc_base = ctrl.acc_clear ? '0 : acc_ff;
      acc_sum  = {1'b0, acc_base} + {1'b0, sq_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctrl.acc_en) begin
         if (active) begin
            acc_ff <= acc_sum[ACC_BITS] ? ACC_MAX : acc_sum[ACC_BITS-1:0];
         end else if (ctrl.acc_clear) begin
            acc_ff <= '0;
         end
      end
   end

   // Search stage: keep the running best unless this cell is strictly closer.
   assign take_own = active && (acc_ff < scan_dist_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_valid_ff <= 1'b0;
      end else begin
         scan_valid_ff <= scan_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_valid_in) begin
         scan_dist_ff <= take_own ? acc_ff : scan_dist_in;
         scan_idx_ff  <= take_own ? CLU_W'(CELL_INDEX) : scan_idx_in;
      end
   end

   assign scan_valid_out = scan_valid_ff;
   assign scan_dist_out  = scan_dist_ff;
   assign scan_idx_out   = scan_idx_ff;

endmodule

/* rtl/nca_seq.sv */
// Item sequencer: handshakes, configuration registers, cell strobes, the
// change counter and the result register. Depends on nca_pkg.
module nca_seq
   import nca_pkg::*;
#(
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
   parameter int MAX_DIMS     = DEF_MAX_DIMS,
   parameter int COORD_BITS   = DEF_COORD_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Item channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [OP_BITS-1:0]                    req_op,
   input  logic [CLUSTER_INDEX_BITS-1:0]         req_cluster_index,
   input  logic [DIM_INDEX_BITS-1:0]             req_dim_index,
   input  logic signed [COORD_BITS-1:0]          req_coord_value,
   input  logic [LABEL_BITS-1:0]                 req_prior_label,
   // Configuration channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]             csr_index,
   input  logic [CFG_BITS-1:0]                   csr_wdata,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [LABEL_BITS-1:0]                 rsp_assigned_label,
   output logic                                  rsp_label_changed,
   output logic [COUNT_BITS-1:0]                 rsp_change_count,
   // Cell side
   output nca_cell_ctrl_type                     cell_ctrl,
   output logic [MAX_CLUSTERS-1:0]               wr_mask,
   output logic [MAX_CLUSTERS-1:0]               active_mask,
   output logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0] cell_addr,
   output logic signed [COORD_BITS-1:0]          cell_coord,
   output logic                                  seed_valid,
   input  logic                                  chain_valid,
   input  logic [$clog2(MAX_CLUSTERS)-1:0]       chain_idx
);

   localparam int CLU_W  = $clog2(MAX_CLUSTERS);
   localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int NK_W   = $clog2(MAX_CLUSTERS + 1);
   localparam int ND_W   = $clog2(MAX_DIMS + 1);
   localparam int CW     = (NK_W > CFG_BITS) ? NK_W : CFG_BITS;
   localparam int DW     = (ND_W > CFG_BITS) ? ND_W : CFG_BITS;
   localparam int LBL_W  = CLU_W + 1;
   localparam int CMP_W  = (LBL_W > LABEL_BITS) ? LBL_W : LABEL_BITS;

   nca_state_type                 state_ff;
   nca_state_type                 state_in;
   logic [CFG_BITS-1:0]           clusters_ff;
   logic [CFG_BITS-1:0]           dims_ff;
   logic [OP_BITS-1:0]            op_ff;
   logic [CLUSTER_INDEX_BITS-1:0] ci_ff;
   logic [DIM_INDEX_BITS-1:0]     di_ff;
   logic signed [COORD_BITS-1:0]  coord_ff;
   logic [LABEL_BITS-1:0]         prior_ff;
   logic [CLU_W-1:0]              best_ff;
   logic [COUNT_BITS-1:0]         count_ff;
   logic                          rsp_valid_ff;
   logic [LABEL_BITS-1:0]         rsp_label_ff;
   logic                          rsp_changed_ff;
   logic [COUNT_BITS-1:0]         rsp_count_ff;

   logic [CW-1:0]         nk;
   logic [DW-1:0]         nd;
   logic [DW-1:0]         di_wide;
   logic                  load_ok;
   logic                  point_ok;
   logic                  last_dim;
   logic [LBL_W-1:0]      label_full;
   logic                  changed;
   logic [COUNT_BITS-1:0] count_next;
   logic                  out_free;
   logic                  req_xfer;
   logic                  emit_go;
   logic                  pass_clear;

   // Register values clamped to the supported range: zero acts as one.
   always_comb begin
      if (clusters_ff == '0) begin
         nk = CW'(1);
      end else if (CW'(clusters_ff) > CW'(MAX_CLUSTERS)) begin
         nk = CW'(MAX_CLUSTERS);
      end else begin
         nk = CW'(clusters_ff);
      end
      if (dims_ff == '0) begin
         nd = DW'(1);
      end else if (DW'(dims_ff) > DW'(MAX_DIMS)) begin
         nd = DW'(MAX_DIMS);
      end else begin
         nd = DW'(dims_ff);
      end
   end

   // Decode of the held item.
   always_comb begin
      di_wide  = DW'(di_ff);
      load_ok  = (CW'(ci_ff) < CW'(MAX_CLUSTERS)) && (di_wide < DW'(MAX_DIMS));
      point_ok = di_wide < nd;
      last_dim = di_wide == (nd - DW'(1));
   end

   // Per-cell enables: the active clusters and the target of a load.
   for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_mask
      assign active_mask[k] = CW'(k) < nk;
      assign wr_mask[k]     = (state_ff == ST_DECODE) && (op_ff == OP_LOAD) && load_ok
                              && (CW'(ci_ff) == CW'(k));
   end

   assign cell_addr  = DIM_W'(di_ff);
   assign cell_coord = coord_ff;

   // Label, change flag and the saturating change count for a result.
   always_comb begin
      label_full = LBL_W'(best_ff) + LBL_W'(1);
      changed    = CMP_W'(label_full) != CMP_W'(prior_ff);
      count_next = (changed && (count_ff != COUNT_MAX)) ? count_ff + COUNT_BITS'(1)
                                                        : count_ff;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_xfer = req_valid && req_ready;

   // Next state and strobes.
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cell_ctrl  = '0;
      seed_valid = 1'b0;
      emit_go    = 1'b0;
      pass_clear = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            case (op_ff)
               OP_START: begin
                  pass_clear = 1'b1;
               end
               OP_POINT: begin
                  if (point_ok) begin
                     cell_ctrl.rd_en = 1'b1;
                     state_in        = ST_SQUARE;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SQUARE: begin
            cell_ctrl.sq_en = 1'b1;
            state_in        = ST_ACCUM;
         end
         ST_ACCUM: begin
            cell_ctrl.acc_en    = 1'b1;
            cell_ctrl.acc_clear = di_ff == '0;
            state_in            = last_dim ? ST_SEED : ST_IDLE;
         end
         ST_SEED: begin
            seed_valid = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (chain_valid) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit_go  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration writes; the port never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clusters_ff <= CLUSTERS_RESET;
         dims_ff     <= DIMS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CLUSTERS: clusters_ff <= csr_wdata;
            CSR_DIMS:     dims_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Item capture on an input transfer, winner capture at the end of the search.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff    <= req_op;
         ci_ff    <= req_cluster_index;
         di_ff    <= req_dim_index;
         coord_ff <= req_coord_value;
         prior_ff <= req_prior_label;
      end
      if ((state_ff == ST_SCAN) && chain_valid) begin
         best_ff <= chain_idx;
      end
   end

   // Change counter: cleared by a start-pass item, bumped by each changed point.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (pass_clear) begin
         count_ff <= '0;
      end else if (emit_go) begin
         count_ff <= count_next;
      end
   end

   // Result register; it frees itself on an output transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_label_ff   <= LABEL_BITS'(label_full);
         rsp_changed_ff <= changed;
         rsp_count_ff   <= count_next;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_assigned_label = rsp_label_ff;
   assign rsp_label_changed  = rsp_changed_ff;
   assign rsp_change_count   = rsp_count_ff;

`ifndef SYNTHESIS
   // A new result only appears out of the emit state.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result raised outside the emit state");

   // The search chain only delivers a winner while the sequencer waits for it.
   a_chain_in_scan: assert property (@(posedge clock) disable iff (reset)
      chain_valid |-> state_ff == ST_SCAN)
      else $error("search chain output outside the scan state");

   // A load writes at most one cell.
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_mask))
      else $error("load enables more than one cell");

   // The change count only drops on a start-pass item.
   a_count_drop: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff < $past(count_ff)))
      |-> ($past(state_ff) == ST_DECODE && $past(op_ff) == OP_START))
      else $error("change count dropped without a start-pass item");
`endif

endmodule

/* rtl/nearest_centroid_assign_top.sv */
// Top level of the nearest-centroid assignment block: sequencer and a chain of
// centroid cells. Depends on nca_pkg, nca_seq and nca_cell.
//
//   channel  ports              direction  content
//   req      req_valid/ready    in         one centroid or point coordinate, or a start pass
//   rsp      rsp_valid/ready    out        label, changed flag, change count
//   csr      csr_valid/ready    in         register index and write data
//
// A load, start-pass or ignored item passes through the decode state only, and
// a point coordinate short of the last dimension also through the square and
// accumulate states. The last dimension adds a seed state, the search rippling
// down the cell chain and an emit state. Reset is synchronous; the centroid
// store has no clearing pass and holds garbage until loaded. A stalled result waits
// in the output register while later items are accepted until the next result.
module nearest_centroid_assign_top
   import nca_pkg::*;
#(
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
   parameter int MAX_DIMS     = DEF_MAX_DIMS,
   parameter int COORD_BITS   = DEF_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [OP_BITS-1:0]            req_op,
   input  logic [CLUSTER_INDEX_BITS-1:0] req_cluster_index,
   input  logic [DIM_INDEX_BITS-1:0]     req_dim_index,
   input  logic signed [COORD_BITS-1:0]  req_coord_value,
   input  logic [LABEL_BITS-1:0]         req_prior_label,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CFG_BITS-1:0]           csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [LABEL_BITS-1:0]         rsp_assigned_label,
   output logic                          rsp_label_changed,
   output logic [COUNT_BITS-1:0]         rsp_change_count
);

   localparam int CLU_W = $clog2(MAX_CLUSTERS);
   localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   nca_cell_ctrl_type            cell_ctrl;
   logic [MAX_CLUSTERS-1:0]      wr_mask;
   logic [MAX_CLUSTERS-1:0]      active_mask;
   logic [DIM_W-1:0]             cell_addr;
   logic signed [COORD_BITS-1:0] cell_coord;
   logic                         seed_valid;
   logic                         chain_valid [MAX_CLUSTERS+1];
   logic [ACC_BITS-1:0]          chain_dist  [MAX_CLUSTERS+1];
   logic [CLU_W-1:0]             chain_idx   [MAX_CLUSTERS+1];

   // Sequencer and result register.
   nca_seq #(
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .MAX_DIMS     (MAX_DIMS),
      .COORD_BITS   (COORD_BITS)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_cluster_index  (req_cluster_index),
      .req_dim_index      (req_dim_index),
      .req_coord_value    (req_coord_value),
      .req_prior_label    (req_prior_label),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_assigned_label (rsp_assigned_label),
      .rsp_label_changed  (rsp_label_changed),
      .rsp_change_count   (rsp_change_count),
      .cell_ctrl          (cell_ctrl),
      .wr_mask            (wr_mask),
      .active_mask        (active_mask),
      .cell_addr          (cell_addr),
      .cell_coord         (cell_coord),
      .seed_valid         (seed_valid),
      .chain_valid        (chain_valid[MAX_CLUSTERS]),
      .chain_idx          (chain_idx[MAX_CLUSTERS])
   );

   // The search enters the chain with the worst possible distance and cluster 0.
   assign chain_valid[0] = seed_valid;
   assign chain_dist[0]  = ACC_MAX;
   assign chain_idx[0]   = '0;

   // One cell per centroid, each feeding its neighbor.
   for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
      nca_cell #(
         .MAX_CLUSTERS (MAX_CLUSTERS),
         .MAX_DIMS     (MAX_DIMS),
         .COORD_BITS   (COORD_BITS),
         .CELL_INDEX   (k)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (cell_ctrl),
         .wr_en          (wr_mask[k]),
         .active         (active_mask[k]),
         .addr           (cell_addr),
         .coord          (cell_coord),
         .scan_valid_in  (chain_valid[k]),
         .scan_dist_in   (chain_dist[k]),
         .scan_idx_in    (chain_idx[k]),
         .scan_valid_out (chain_valid[k+1]),
         .scan_dist_out  (chain_dist[k+1]),
         .scan_idx_out   (chain_idx[k+1])
      );
   end

endmodule
